[hdl/oid_pkg.sv]
// Shared types, constants and helpers for the object identifier arc decoder.
// Used by oid_core, oid_result_fifo and oid_subidentifier_decoder_unit.
// No dependencies.
`timescale 1ns / 1ps

package oid_pkg;

    // Arc and accumulator width
    localparam int ARC_WIDTH = 64;

    // Octet layout: continuation flag and seven data bits
    localparam int GROUP_BITS = 7;
    localparam logic [7:0] GROUP_MASK = 8'h7F;
    localparam logic [7:0] CONT_BIT = 8'h80;

    // Split points of the first subidentifier
    localparam logic [ARC_WIDTH-1:0] ARC_DIV = ARC_WIDTH'(40);
    localparam logic [ARC_WIDTH-1:0] ARC_DIV2 = ARC_WIDTH'(2 * 40);

    // Result queue depth: must hold two arcs from one octet
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    // One content octet
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_content;
    } t_in_item;

    // One decoded arc or error result
    typedef struct packed {
        logic [ARC_WIDTH-1:0] arc_value;
        logic                 last_arc;
        logic                 truncated;
        logic                 overflowed;
    } t_out_item;

    // Results produced by one octet: count of zero, one or two
    typedef struct packed {
        logic [1:0] count;
        t_out_item  res0;
        t_out_item  res1;
    } t_dec_res;

    // Build a result item
    function automatic t_out_item make_res(input logic [ARC_WIDTH-1:0] arc,
                                           input logic last,
                                           input logic trunc,
                                           input logic ovf);
        t_out_item r;
        r.arc_value  = arc;
        r.last_arc   = last;
        r.truncated  = trunc;
        r.overflowed = ovf;
        return r;
    endfunction

endpackage

[hdl/oid_core.sv]
// Subidentifier accumulator and arc split for one registered octet per cycle while i_fire is high.
// Holds accumulator, first-subidentifier and overflow state. Uses oid_pkg.
`timescale 1ns / 1ps

module oid_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  oid_pkg::t_in_item i_item,
    output oid_pkg::t_dec_res o_dec
);

    logic [oid_pkg::ARC_WIDTH-1:0] r_acc, n_acc;
    logic                          r_first_pending, n_first_pending;
    logic                          r_ovf_seen, n_ovf_seen;

    // Accumulate the octet and work out the results it causes
    always_comb begin
        logic [oid_pkg::ARC_WIDTH-1:0] acc_step;
        logic [oid_pkg::ARC_WIDTH-1:0] sub_val;
        logic                          ovf_step;
        logic                          more;
        logic                          eoc;
        logic [1:0]                    first_arc;

        more = (i_item.data_byte & oid_pkg::CONT_BIT) != 8'h00;
        eoc  = i_item.end_of_content;

        // Shift in seven bits unless set bits would leave the top
        acc_step = r_acc;
        ovf_step = r_ovf_seen;
        if (!r_ovf_seen) begin
            if (r_acc[oid_pkg::ARC_WIDTH-1 -: oid_pkg::GROUP_BITS] != '0) begin
                ovf_step = 1'b1;
            end else begin
                acc_step = {r_acc[oid_pkg::ARC_WIDTH-oid_pkg::GROUP_BITS-1:0],
                            i_item.data_byte[oid_pkg::GROUP_BITS-1:0]};
            end
        end

        // First arc is 0, 1 or 2; second is the remainder
        if (acc_step < oid_pkg::ARC_DIV) begin
            first_arc = 2'd0;
            sub_val   = '0;
        end else if (acc_step < oid_pkg::ARC_DIV2) begin
            first_arc = 2'd1;
            sub_val   = oid_pkg::ARC_DIV;
        end else begin
            first_arc = 2'd2;
            sub_val   = oid_pkg::ARC_DIV2;
        end

        o_dec.count = 2'd0;
        o_dec.res0  = oid_pkg::make_res(acc_step, eoc, 1'b0, 1'b0);
        o_dec.res1  = oid_pkg::make_res(acc_step - sub_val, eoc, 1'b0, 1'b0);

        n_acc           = acc_step;
        n_ovf_seen      = ovf_step;
        n_first_pending = r_first_pending;

        if (more) begin
            // Truncated identifier: report and start over
            if (eoc) begin
                o_dec.count     = 2'd1;
                o_dec.res0      = oid_pkg::make_res('0, 1'b1, 1'b1, ovf_step);
                n_acc           = '0;
                n_ovf_seen      = 1'b0;
                n_first_pending = 1'b1;
            end
        end else begin
            if (ovf_step) begin
                o_dec.count = 2'd1;
                o_dec.res0  = oid_pkg::make_res('0, eoc, 1'b0, 1'b1);
            end else if (r_first_pending) begin
                o_dec.count = 2'd2;
                o_dec.res0  = oid_pkg::make_res(oid_pkg::ARC_WIDTH'(first_arc),
                                                1'b0, 1'b0, 1'b0);
            end else begin
                o_dec.count = 2'd1;
            end
            n_acc           = '0;
            n_ovf_seen      = 1'b0;
            n_first_pending = eoc;
        end
    end

    // Hold state; advance only on a processed octet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc           <= '0;
            r_first_pending <= 1'b1;
            r_ovf_seen      <= 1'b0;
        end else if (i_fire) begin
            r_acc           <= n_acc;
            r_first_pending <= n_first_pending;
            r_ovf_seen      <= n_ovf_seen;
        end
    end

`ifndef SYNTHESIS
    // A finished identifier leaves the decoder expecting a first subidentifier
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_dec.count != 2'd0 &&
         ((o_dec.count == 2'd1 && o_dec.res0.last_arc) ||
          (o_dec.count == 2'd2 && o_dec.res1.last_arc)))
        |=> (r_first_pending && r_acc == '0 && !r_ovf_seen))
        else $error("state not cleared after last arc");

    // Only the first subidentifier splits into two arcs
    a_pair_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_dec.count == 2'd2)
        |-> (r_first_pending && !o_dec.res0.truncated && !o_dec.res0.overflowed))
        else $error("arc pair outside first subidentifier");
`endif

endmodule

[hdl/oid_result_fifo.sv]
// Small result queue: takes up to two items a cycle, hands out one unless stalled.
// Uses oid_pkg for the item type and depth.
`timescale 1ns / 1ps

module oid_result_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  oid_pkg::t_dec_res  i_wr,
    output logic               o_room2,
    output logic               o_valid,
    input  logic               i_stall,
    output oid_pkg::t_out_item o_item
);

    oid_pkg::t_out_item r_mem [oid_pkg::RES_DEPTH];
    logic [oid_pkg::RES_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [oid_pkg::RES_CNT_W-1:0] r_count;
    logic [oid_pkg::RES_PTR_W-1:0] wr_ptr1;
    logic                          rd_fire;

    assign wr_ptr1 = r_wr_ptr + oid_pkg::RES_PTR_W'(1);
    assign rd_fire = o_valid && !i_stall;
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign o_room2 = r_count <= oid_pkg::RES_CNT_W'(oid_pkg::RES_DEPTH - 2);

    // Store new results in free slots
    always_ff @(posedge i_clk) begin
        if (i_wr.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_wr.res0;
        end
        if (i_wr.count == 2'd2) begin
            r_mem[wr_ptr1] <= i_wr.res1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + oid_pkg::RES_PTR_W'(i_wr.count);
            if (rd_fire) begin
                r_rd_ptr <= r_rd_ptr + oid_pkg::RES_PTR_W'(1);
            end
            r_count <= r_count + oid_pkg::RES_CNT_W'(i_wr.count)
                       - oid_pkg::RES_CNT_W'(rd_fire);
        end
    end

`ifndef SYNTHESIS
    // Never write more items than there are free slots
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.count != 2'd0) |-> o_room2)
        else $error("result queue overrun");

    // Count stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= oid_pkg::RES_CNT_W'(oid_pkg::RES_DEPTH))
        else $error("result count out of range");
`endif

endmodule

[hdl/oid_subidentifier_decoder_unit.sv]
// Top level of the object identifier arc decoder.
// Instantiates oid_core and oid_result_fifo; uses oid_pkg.
`timescale 1ns / 1ps

// Decodes the content octets of an OBJECT IDENTIFIER, one octet per item, into
// 64-bit arcs. An octet is taken every cycle unless the input stalls; it is
// held in the input register, decoded into up to two results and queued in
// the result queue, from which each arc is read. The output port delivers one
// arc a cycle while not stalled, so the first subidentifier of an identifier,
// which yields two arcs, holds the output for both; the four-entry result
// queue absorbs this, and the input stalls only when the queue has fewer than
// two free slots. Truncated content and subidentifiers wider than 64 bits give
// error results with arc value zero and the truncated or overflowed flag set.
module oid_subidentifier_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  oid_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output oid_pkg::t_out_item o_out_item
);

    logic              r_in_valid;
    oid_pkg::t_in_item r_in_item;
    logic              room2;
    logic              fire;
    oid_pkg::t_dec_res dec;
    oid_pkg::t_dec_res wr;

    // Decode the held octet once two result slots are free
    assign fire       = r_in_valid && room2;
    assign o_in_stall = r_in_valid && !room2;

    always_comb begin
        wr = dec;
        if (!fire) begin
            wr.count = 2'd0;
        end
    end

    // Input register: hold while stalled, load when empty or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    oid_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_item),
        .o_dec   (dec)
    );

    oid_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // An empty input register never stalls the source
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("stall with empty input register");
`endif

endmodule
